// File: rtl/ttc_pkg.sv
package ttc_pkg;

    // Character codes the tokenizer reacts to.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    // Depths of the queue between the stages and of the result queue.
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    typedef struct packed {
        logic is_sep;
        logic is_lf;
        logic is_star;
        logic is_slash;
        logic is_hash;
        logic is_quote;
    } ttc_class_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
        ttc_class_t cls;
    } ttc_item_t;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       token_last;
        logic       in_string;
    } ttc_result_t;

endpackage

// File: rtl/ttc_fifo.sv
module ttc_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = data_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/ttc_front.sv
module ttc_front
    import ttc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  logic [7:0] text_byte,
    input  logic      end_of_text,
    output ttc_item_t item,
    output logic      item_valid,
    input  logic      item_pop
);

    ttc_item_t  in_item;
    ttc_class_t cls;
    logic       item_empty;
    logic [$bits(ttc_item_t)-1:0] item_bits;

    always_comb
    begin
        cls.is_lf    = (text_byte == CH_LF);
        cls.is_star  = (text_byte == CH_STAR);
        cls.is_slash = (text_byte == CH_SLASH);
        cls.is_hash  = (text_byte == CH_HASH);
        cls.is_quote = (text_byte == CH_QUOTE);
        cls.is_sep   = (text_byte == CH_NUL)    || (text_byte == CH_SPACE)  ||
                       (text_byte == CH_TAB)    || (text_byte == CH_CR)     ||
                       (text_byte == CH_LF)     || (text_byte == CH_LPAREN) ||
                       (text_byte == CH_RPAREN) || (text_byte == CH_STAR)   ||
                       (text_byte == CH_COLON)  || (text_byte == CH_SEMI);
        in_item.text_byte   = text_byte;
        in_item.end_of_text = end_of_text;
        in_item.cls         = cls;
    end

    ttc_fifo
    #(
        .WIDTH ($bits(ttc_item_t)),
        .DEPTH (MID_DEPTH)
    )
    u_mid_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (in_item),
        .full      (full),
        .pop       (item_pop),
        .pop_data  (item_bits),
        .empty     (item_empty)
    );

    assign item       = ttc_item_t'(item_bits);
    assign item_valid = !item_empty;

endmodule

// File: rtl/ttc_lexer.sv
module ttc_lexer
    import ttc_pkg::*;
#(
    parameter int TOKEN_CAPACITY = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ttc_item_t   item,
    input  logic        item_valid,
    output logic        item_pop,
    input  logic        res_full,
    output logic        res_valid,
    output ttc_result_t res
);

    localparam int LEN_W = $clog2(TOKEN_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(TOKEN_CAPACITY - 1);
    localparam logic [LEN_W-1:0] STR_FULL = LEN_W'(TOKEN_CAPACITY - 2);

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BLOCK_STAR,
        MODE_SLASH,
        MODE_TOKEN,
        MODE_STRING
    } mode_t;

    mode_t            mode_reg,       mode_next;
    logic [7:0]       held_char_reg,  held_char_next;
    logic             held_valid_reg, held_valid_next;
    logic [LEN_W-1:0] tok_len_reg,    tok_len_next;
    logic             string_reg,     string_next;

    ttc_class_t cls;
    logic [7:0] c;

    // The back stage works whenever a classified byte waits and the result queue has room.
    assign item_pop = item_valid && !res_full;
    assign c        = item.text_byte;
    assign cls      = item.cls;

    always_comb
    begin
        logic             do_token;
        logic [7:0]       tok_held;
        logic [LEN_W-1:0] tok_len;
        logic [LEN_W-1:0] tok_inc;
        logic             emitted;

        mode_next       = mode_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        tok_len_next    = tok_len_reg;
        string_next     = string_reg;
        res_valid       = 1'b0;
        res.token_byte  = held_char_reg;
        res.token_last  = 1'b0;
        res.in_string   = 1'b0;
        do_token        = 1'b0;
        tok_held        = held_char_reg;
        tok_len         = tok_len_reg;
        tok_inc         = tok_len + 1'b1;
        emitted         = 1'b0;

        if (item_pop)
        begin
            if (item.end_of_text)
            begin
                if (held_valid_reg)
                begin
                    res_valid      = 1'b1;
                    res.token_byte = held_char_reg;
                    res.token_last = 1'b1;
                    res.in_string  = string_reg;
                end
                else if (mode_reg == MODE_STRING)
                begin
                    res_valid      = 1'b1;
                    res.token_byte = CH_QUOTE;
                    res.token_last = 1'b1;
                    res.in_string  = 1'b1;
                end
                else if (mode_reg == MODE_SLASH)
                begin
                    res_valid      = 1'b1;
                    res.token_byte = CH_SLASH;
                    res.token_last = 1'b1;
                end
                mode_next       = MODE_SKIP;
                held_char_next  = '0;
                held_valid_next = 1'b0;
                tok_len_next    = '0;
                string_next     = 1'b0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_LINE:
                    begin
                        if (cls.is_lf)
                        begin
                            mode_next = MODE_SKIP;
                        end
                    end
                    MODE_BLOCK:
                    begin
                        if (cls.is_star)
                        begin
                            mode_next = MODE_BLOCK_STAR;
                        end
                    end
                    MODE_BLOCK_STAR:
                    begin
                        if (cls.is_slash)
                        begin
                            mode_next = MODE_SKIP;
                        end
                        else if (!cls.is_star)
                        begin
                            mode_next = MODE_BLOCK;
                        end
                    end
                    MODE_SLASH:
                    begin
                        if (cls.is_slash)
                        begin
                            mode_next = MODE_LINE;
                        end
                        else if (cls.is_star)
                        begin
                            mode_next = MODE_BLOCK_STAR;
                        end
                        else
                        begin
                            // The lone slash becomes the first byte of a plain token.
                            do_token = 1'b1;
                            tok_held = CH_SLASH;
                            tok_len  = LEN_W'(1);
                        end
                    end
                    MODE_TOKEN:
                    begin
                        do_token = 1'b1;
                    end
                    MODE_STRING:
                    begin
                        if ((tok_len_reg >= STR_FULL) || cls.is_quote)
                        begin
                            res_valid     = 1'b1;
                            res.in_string = 1'b1;
                            mode_next     = MODE_SKIP;
                            if (held_valid_reg)
                            begin
                                // The closing quote stays held and goes out as last later.
                                res.token_byte = held_char_reg;
                                held_char_next = CH_QUOTE;
                            end
                            else
                            begin
                                res.token_byte = CH_QUOTE;
                                res.token_last = 1'b1;
                                string_next    = 1'b0;
                                tok_len_next   = '0;
                            end
                        end
                        else
                        begin
                            res_valid     = 1'b1;
                            res.in_string = 1'b1;
                            if (held_valid_reg)
                            begin
                                res.token_byte = held_char_reg;
                                held_char_next = c;
                            end
                            else
                            begin
                                res.token_byte = c;
                            end
                            tok_len_next = tok_len_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_SKIP;
                        if (held_valid_reg)
                        begin
                            res_valid       = 1'b1;
                            res.token_byte  = held_char_reg;
                            res.token_last  = 1'b1;
                            res.in_string   = string_reg;
                            held_valid_next = 1'b0;
                            tok_len_next    = '0;
                            string_next     = 1'b0;
                            emitted         = 1'b1;
                        end
                        if (cls.is_sep)
                        begin
                            // Separators between tokens are dropped.
                        end
                        else if (cls.is_hash)
                        begin
                            mode_next = MODE_LINE;
                        end
                        else if (cls.is_slash)
                        begin
                            mode_next = MODE_SLASH;
                        end
                        else if (cls.is_quote)
                        begin
                            string_next  = 1'b1;
                            tok_len_next = LEN_W'(1);
                            mode_next    = MODE_STRING;
                            if (!emitted)
                            begin
                                res_valid      = 1'b1;
                                res.token_byte = CH_QUOTE;
                                res.in_string  = 1'b1;
                            end
                            else
                            begin
                                held_char_next  = CH_QUOTE;
                                held_valid_next = 1'b1;
                            end
                        end
                        else
                        begin
                            string_next     = 1'b0;
                            held_char_next  = c;
                            held_valid_next = 1'b1;
                            tok_len_next    = LEN_W'(1);
                            mode_next       = MODE_TOKEN;
                        end
                    end
                endcase

                if (do_token)
                begin
                    tok_inc        = tok_len + 1'b1;
                    res_valid      = 1'b1;
                    res.token_byte = tok_held;
                    res.in_string  = 1'b0;
                    if (cls.is_sep)
                    begin
                        res.token_last  = 1'b1;
                        held_valid_next = 1'b0;
                        tok_len_next    = '0;
                        string_next     = 1'b0;
                        mode_next       = MODE_SKIP;
                    end
                    else
                    begin
                        res.token_last  = 1'b0;
                        held_char_next  = c;
                        held_valid_next = 1'b1;
                        string_next     = 1'b0;
                        tok_len_next    = tok_inc;
                        // At capacity the held byte is known to end the token.
                        mode_next = (tok_inc >= LEN_MAX) ? MODE_SKIP : MODE_TOKEN;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SKIP;
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
            tok_len_reg    <= '0;
            string_reg     <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            tok_len_reg    <= tok_len_next;
            string_reg     <= string_next;
        end
    end

endmodule

// File: rtl/text_tokenizer_with_comments.sv
// Streaming tokenizer: text bytes in, token bytes out, comments and separators dropped.
// Input channel: a transaction is taken at a rising edge with push high and full low;
// it carries text_byte and end_of_text. An end_of_text transaction consumes no text
// byte; it flushes any pending token byte and returns the lexer to its idle state.
// Result channel: while empty is low the oldest result sits on token_byte, token_last
// and in_string; a transaction completes at a rising edge with pop high.
// Each input byte yields zero or one result. A classifier stage writes bytes into a
// two-entry queue; the lexer state machine takes one byte a cycle from it, while the
// result queue has room, and writes into a two-entry result queue. One byte a cycle
// is sustained while pop keeps up; a result passes through the input queue and then
// the result queue, both registered. Plain token bytes come out one byte late, since
// a byte is held until the next one shows whether it ends the token.
// When pop stays low the result queue fills, the lexer stops, then the input queue
// fills and full rises; nothing is lost. Reset empties both queues and leaves the
// lexer between tokens with nothing held.
module text_tokenizer_with_comments
    import ttc_pkg::*;
#(
    parameter int TOKEN_CAPACITY = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] token_byte,
    output logic       token_last,
    output logic       in_string
);

    ttc_item_t   item;
    logic        item_valid;
    logic        item_pop;
    logic        res_valid;
    logic        res_full;
    ttc_result_t res;
    logic [$bits(ttc_result_t)-1:0] out_bits;
    ttc_result_t out_res;

    ttc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .item        (item),
        .item_valid  (item_valid),
        .item_pop    (item_pop)
    );

    ttc_lexer
    #(
        .TOKEN_CAPACITY (TOKEN_CAPACITY)
    )
    u_lexer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_valid  (res_valid),
        .res        (res)
    );

    ttc_fifo
    #(
        .WIDTH ($bits(ttc_result_t)),
        .DEPTH (OUT_DEPTH)
    )
    u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (out_bits),
        .empty     (empty)
    );

    assign out_res    = ttc_result_t'(out_bits);
    assign token_byte = out_res.token_byte;
    assign token_last = out_res.token_last;
    assign in_string  = out_res.in_string;

    // The lexer must never produce a result that the result queue cannot take.
    assert property (@(posedge clk) disable iff (!rst_n) res_valid |-> !res_full)
        else $error("result produced while result queue full");

    // The back stage never idles while a byte waits and there is room for its result.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (item_valid && !res_full) |-> item_pop)
        else $error("lexer stalled without cause");

    // Unless end of text cuts it short, a string token ends on its closing quote.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (res_valid && res.in_string && res.token_last && !item.end_of_text) |->
                     (res.token_byte == CH_QUOTE))
        else $error("string token ended on a byte other than a quote");

endmodule

// File: test/tb_top.sv
module tb_top;
    import ttc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOKEN_CAP = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1650;
    localparam int MAX_REPORTS = 30;
    localparam ttc_result_t NO_RES = '0;

    typedef enum logic [2:0] {
        LX_SKIP,
        LX_LINE,
        LX_BLOCK,
        LX_BLOCK_STAR,
        LX_SLASH,
        LX_TOKEN,
        LX_STRING
    } lex_mode_t;

    typedef struct {
        logic [7:0]  ch;
        logic        eot;
        bit          typed;
        ttc_result_t res;
    } text_step_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] text_byte;
    logic       end_of_text;
    logic       empty;
    logic       pop;
    logic [7:0] token_byte;
    logic       token_last;
    logic       in_string;

    // Lexer state mirrored by the predictor.
    lex_mode_t  lx_mode;
    logic [7:0] lx_held;
    logic       lx_held_ok;
    int         lx_len;
    logic       lx_str;

    ttc_result_t tokens_due[$];
    int          errors;
    int          sent_count;
    int          send_idle;
    int          recv_idle;
    int          cycle_count;

    // Rows with a typed result are checked against that value; the rest use the predictor.
    text_step_t opening_script [25] = '{
        '{8'h00,    1'b1, 1'b0, NO_RES},
        '{"a",      1'b0, 1'b0, NO_RES},
        '{8'hFF,    1'b0, 1'b1, '{"a", 1'b0, 1'b0}},
        '{CH_SPACE, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
        '{CH_HASH,  1'b0, 1'b0, NO_RES},
        '{"x",      1'b0, 1'b0, NO_RES},
        '{CH_LF,    1'b0, 1'b0, NO_RES},
        '{CH_SLASH, 1'b0, 1'b0, NO_RES},
        '{CH_STAR,  1'b0, 1'b0, NO_RES},
        '{CH_SLASH, 1'b0, 1'b0, NO_RES},
        '{CH_SLASH, 1'b0, 1'b0, NO_RES},
        '{"b",      1'b0, 1'b1, '{CH_SLASH, 1'b0, 1'b0}},
        '{8'hFF,    1'b1, 1'b1, '{"b", 1'b1, 1'b0}},
        '{CH_QUOTE, 1'b0, 1'b1, '{CH_QUOTE, 1'b0, 1'b1}},
        '{"q",      1'b0, 1'b1, '{"q", 1'b0, 1'b1}},
        '{CH_QUOTE, 1'b0, 1'b1, '{CH_QUOTE, 1'b1, 1'b1}},
        '{CH_QUOTE, 1'b0, 1'b1, '{CH_QUOTE, 1'b0, 1'b1}},
        '{8'h00,    1'b1, 1'b1, '{CH_QUOTE, 1'b1, 1'b1}},
        '{CH_SLASH, 1'b0, 1'b0, NO_RES},
        '{8'h00,    1'b1, 1'b1, '{CH_SLASH, 1'b1, 1'b0}},
        '{CH_SLASH, 1'b0, 1'b0, NO_RES},
        '{CH_STAR,  1'b0, 1'b0, NO_RES},
        '{8'h00,    1'b1, 1'b0, NO_RES},
        '{"k",      1'b0, 1'b0, NO_RES},
        '{CH_TAB,   1'b0, 1'b1, '{"k", 1'b1, 1'b0}}
    };

    text_tokenizer_with_comments #(.TOKEN_CAPACITY(TOKEN_CAP)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop),
        .token_byte  (token_byte),
        .token_last  (token_last),
        .in_string   (in_string)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic is_sep(input logic [7:0] c);
        return c inside {CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF,
                         CH_LPAREN, CH_RPAREN, CH_STAR, CH_COLON, CH_SEMI};
    endfunction

    function automatic void lexer_clear();
        lx_mode = LX_SKIP;
        lx_held = 8'h00;
        lx_held_ok = 1'b0;
        lx_len = 0;
        lx_str = 1'b0;
    endfunction

    // One step of a plain token takes one byte; the held byte always comes out.
    function automatic bit plain_step(input logic [7:0] c, output ttc_result_t r);
        if (is_sep(c))
        begin
            r = '{lx_held, 1'b1, 1'b0};
            lx_held_ok = 1'b0;
            lx_len = 0;
            lx_mode = LX_SKIP;
        end
        else
        begin
            r = '{lx_held, 1'b0, 1'b0};
            lx_held = c;
            lx_len++;
            // The held byte now is known to be the last one of a full token.
            if (lx_len >= TOKEN_CAP - 1)
                lx_mode = LX_SKIP;
        end
        return 1'b1;
    endfunction

    function automatic bit predict_token(input logic [7:0] c, input logic eot,
                                         output ttc_result_t r);
        bit got;
        got = 1'b0;
        r = NO_RES;
        if (eot)
        begin
            if (lx_held_ok)
            begin
                r = '{lx_held, 1'b1, lx_str};
                got = 1'b1;
            end
            else if (lx_mode == LX_STRING)
            begin
                r = '{CH_QUOTE, 1'b1, 1'b1};
                got = 1'b1;
            end
            else if (lx_mode == LX_SLASH)
            begin
                r = '{CH_SLASH, 1'b1, 1'b0};
                got = 1'b1;
            end
            lexer_clear();
            return got;
        end
        case (lx_mode)
            LX_LINE:
                if (c == CH_LF)
                    lx_mode = LX_SKIP;
            LX_BLOCK:
                if (c == CH_STAR)
                    lx_mode = LX_BLOCK_STAR;
            LX_BLOCK_STAR:
                if (c == CH_SLASH)
                    lx_mode = LX_SKIP;
                else if (c != CH_STAR)
                    lx_mode = LX_BLOCK;
            LX_SLASH:
                if (c == CH_SLASH)
                    lx_mode = LX_LINE;
                else if (c == CH_STAR)
                    lx_mode = LX_BLOCK_STAR;
                else
                begin
                    // The slash turns out to open a plain token.
                    lx_str = 1'b0;
                    lx_held = CH_SLASH;
                    lx_held_ok = 1'b1;
                    lx_len = 1;
                    lx_mode = LX_TOKEN;
                    got = plain_step(c, r);
                end
            LX_TOKEN:
                got = plain_step(c, r);
            LX_STRING:
            begin
                if (lx_len >= TOKEN_CAP - 2 || c == CH_QUOTE)
                begin
                    if (lx_held_ok)
                    begin
                        // The closing quote stays held and comes out marked as last.
                        r = '{lx_held, 1'b0, 1'b1};
                        lx_held = CH_QUOTE;
                    end
                    else
                    begin
                        r = '{CH_QUOTE, 1'b1, 1'b1};
                        lx_str = 1'b0;
                        lx_len = 0;
                    end
                    lx_mode = LX_SKIP;
                end
                else
                begin
                    if (lx_held_ok)
                    begin
                        r = '{lx_held, 1'b0, 1'b1};
                        lx_held = c;
                    end
                    else
                        r = '{c, 1'b0, 1'b1};
                    lx_len++;
                end
                got = 1'b1;
            end
            default:
            begin
                lx_mode = LX_SKIP;
                if (lx_held_ok)
                begin
                    r = '{lx_held, 1'b1, lx_str};
                    lx_held_ok = 1'b0;
                    lx_len = 0;
                    lx_str = 1'b0;
                    got = 1'b1;
                end
                if (!is_sep(c))
                begin
                    if (c == CH_HASH)
                        lx_mode = LX_LINE;
                    else if (c == CH_SLASH)
                        lx_mode = LX_SLASH;
                    else if (c == CH_QUOTE)
                    begin
                        lx_str = 1'b1;
                        lx_len = 1;
                        lx_mode = LX_STRING;
                        // With a byte already out this step the quote has to wait.
                        if (!got)
                        begin
                            r = '{CH_QUOTE, 1'b0, 1'b1};
                            got = 1'b1;
                        end
                        else
                        begin
                            lx_held = CH_QUOTE;
                            lx_held_ok = 1'b1;
                        end
                    end
                    else
                    begin
                        lx_str = 1'b0;
                        lx_held = c;
                        lx_held_ok = 1'b1;
                        lx_len = 1;
                        lx_mode = LX_TOKEN;
                    end
                end
            end
        endcase
        return got;
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_sep(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_sep();
        case ($urandom_range(9))
            0: return CH_NUL;
            1: return CH_SPACE;
            2: return CH_TAB;
            3: return CH_CR;
            4: return CH_LF;
            5: return CH_LPAREN;
            6: return CH_RPAREN;
            7: return CH_STAR;
            8: return CH_COLON;
            default: return CH_SEMI;
        endcase
    endfunction

    function automatic logic [7:0] rand_word_start();
        logic [7:0] c;
        do
            c = rand_plain();
        while (c inside {CH_HASH, CH_SLASH, CH_QUOTE});
        return c;
    endfunction

    // Drives one input transaction and records its expected result once it is taken.
    task automatic send(input logic [7:0] c, input logic eot, input bit typed,
                        input ttc_result_t typed_res);
        ttc_result_t r;
        bit          got;
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        text_byte <= c;
        end_of_text <= eot;
        @(posedge clk);
        while (full)
            @(posedge clk);
        got = predict_token(c, eot, r);
        if (typed)
            tokens_due.push_back(typed_res);
        else if (got)
            tokens_due.push_back(r);
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        send(c, 1'b0, 1'b0, NO_RES);
    endtask

    task automatic send_text_end();
        send(8'($urandom_range(255)), 1'b1, 1'b0, NO_RES);
    endtask

    task automatic send_segment();
        int         n;
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 28)
        begin
            n = $urandom_range(1, 12);
            send_byte(rand_word_start());
            repeat (n - 1)
                send_byte(rand_plain());
            if ($urandom_range(3) != 0)
                send_byte(rand_sep());
        end
        else if (pick < 43)
        begin
            n = $urandom_range(0, 10);
            send_byte(CH_QUOTE);
            repeat (n)
            begin
                do
                    c = 8'($urandom_range(255));
                while (c == CH_QUOTE);
                send_byte(c);
            end
            if ($urandom_range(9) != 0)
                send_byte(CH_QUOTE);
        end
        else if (pick < 53)
        begin
            if ($urandom_range(1) != 0)
                send_byte(CH_HASH);
            else
            begin
                send_byte(CH_SLASH);
                send_byte(CH_SLASH);
            end
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                do
                    c = 8'($urandom_range(255));
                while (c == CH_LF);
                send_byte(c);
            end
            send_byte(CH_LF);
        end
        else if (pick < 63)
        begin
            send_byte(CH_SLASH);
            send_byte(CH_STAR);
            n = $urandom_range(0, 8);
            repeat (n)
                send_byte(($urandom_range(2) == 0) ? CH_STAR : 8'($urandom_range(255)));
            send_byte(CH_STAR);
            send_byte(CH_SLASH);
        end
        else if (pick < 72)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
                send_byte(rand_sep());
        end
        else if (pick < 80)
        begin
            send_byte(CH_SLASH);
            send_byte(($urandom_range(1) != 0) ? rand_plain() : rand_sep());
        end
        else if (pick < 88)
        begin
            n = $urandom_range(1, 8);
            repeat (n)
                send_byte(8'($urandom_range(255)));
        end
        else if (pick < 94)
            send_text_end();
        else if (pick < 97)
        begin
            // Runs close to or past the token capacity; a quote may follow straight away.
            n = $urandom_range(TOKEN_CAP - 6, TOKEN_CAP + 4);
            send_byte(rand_word_start());
            repeat (n - 1)
                send_byte(rand_plain());
            if ($urandom_range(1) != 0)
            begin
                send_byte(CH_QUOTE);
                n = $urandom_range(0, 4);
                repeat (n)
                    send_byte(rand_word_start());
                if ($urandom_range(1) != 0)
                    send_text_end();
                else
                    send_byte(CH_QUOTE);
            end
        end
        else
        begin
            n = $urandom_range(TOKEN_CAP - 6, TOKEN_CAP);
            send_byte(CH_QUOTE);
            repeat (n)
            begin
                do
                    c = 8'($urandom_range(255));
                while (c == CH_QUOTE);
                send_byte(c);
            end
            send_byte(CH_QUOTE);
        end
    endtask

    // Result side: accept, compare against the oldest expected token byte, then stall at random.
    initial
    begin
        ttc_result_t want;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (tokens_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected transaction, got byte %h last %b string %b",
                                 $time, token_byte, token_last, in_string);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (token_byte !== want.token_byte)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: token_byte expected %h got %h",
                                     $time, want.token_byte, token_byte);
                    end
                    if (token_last !== want.token_last)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: token_last expected %b got %b",
                                     $time, want.token_last, token_last);
                    end
                    if (in_string !== want.in_string)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: in_string expected %b got %b",
                                     $time, want.in_string, in_string);
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        int phase_end;
        rst_n = 1'b0;
        push = 1'b0;
        text_byte = 8'h00;
        end_of_text = 1'b0;
        errors = 0;
        sent_count = 0;
        cycle_count = 0;
        send_idle = 13;
        recv_idle = 74;
        lexer_clear();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_script[i])
            send(opening_script[i].ch, opening_script[i].eot,
                 opening_script[i].typed, opening_script[i].res);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 13 : (phase == 1) ? 74 : 0;
            recv_idle = (phase == 0) ? 74 : (phase == 1) ? 13 : 0;
            phase_end = sent_count + ITEM_TARGET / 3;
            while (sent_count < phase_end)
                send_segment();
        end

        push <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
